[design/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window minimum block.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  localparam int CFG_W        = 7;
  localparam int WINDOW_RESET = 3;

  typedef struct packed {
    logic load;
    logic rd_front;
    logic front_pop;
    logic front_keep;
    logic rd_back;
    logic back_pop;
    logic write;
    logic emit;
  } swm_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic front_old;
    logic back_greater;
    logic result_due;
    logic out_free;
  } swm_status_t;

endpackage

`default_nettype wire

[design/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl
// Sequencer: accept, front aging, back pops, append and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl
  import swm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire swm_status_t status,
  output swm_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_FRONT_RD  = 3'd1;
  localparam logic [2:0] S_FRONT_CHK = 3'd2;
  localparam logic [2:0] S_BACK_RD   = 3'd3;
  localparam logic [2:0] S_BACK_CHK  = 3'd4;
  localparam logic [2:0] S_WRITE     = 3'd5;
  localparam logic [2:0] S_EMIT      = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        if (status.cnt_zero) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.rd_front = 1'b1;
          state_nxt    = S_FRONT_CHK;
        end
      end
      S_FRONT_CHK: begin
        if (status.front_old) begin
          cmd.front_pop = 1'b1;
          state_nxt     = S_FRONT_RD;
        end else begin
          cmd.front_keep = 1'b1;
          state_nxt      = S_BACK_RD;
        end
      end
      S_BACK_RD: begin
        if (status.cnt_zero) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.rd_back = 1'b1;
          state_nxt   = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        if (status.back_greater) begin
          cmd.back_pop = 1'b1;
          state_nxt    = S_BACK_RD;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = status.result_due ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free)
    else $error("emit without free output register");

  a_write_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> (state_r == S_IDLE || state_r == S_EMIT))
    else $error("write not followed by idle or emit");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_FRONT_RD))
    else $error("accept did not start front aging");

endmodule

`default_nettype wire

[design/swm_dp.sv]
// ----------------------------------------------------------------------------
// swm_dp
// Deque datapath: candidate store, pointers, window config and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_dp
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swm_cmd_t                      cmd,
  output swm_status_t                        status,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          restart,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_data
);

  localparam int IDX_W   = $clog2(WINDOW_MAX);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int POS_MOD = 2 * WINDOW_MAX;
  localparam int POS_W   = $clog2(POS_MOD);
  localparam int EW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SW      = CNT_W + 1;
  localparam int AW      = POS_W + 1;
  localparam int RAM_W   = SAMPLE_BITS + POS_W;

  logic [CFG_W-1:0]              cfg_window_r;
  logic signed [SAMPLE_BITS-1:0] s_r;
  logic signed [SAMPLE_BITS-1:0] front_r;
  logic signed [SAMPLE_BITS-1:0] pend_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;
  logic                          out_valid_r;
  logic [CNT_W-1:0]              cand_count_r;
  logic [IDX_W-1:0]              cand_head_r;
  logic [CNT_W-1:0]              fill_count_r;
  logic [POS_W-1:0]              pos_r;

  logic [EW-1:0]          cfg_ext;
  logic [EW-1:0]          eff_ext;
  logic [CNT_W-1:0]       eff_w;
  logic [SW-1:0]          back_sum;
  logic [SW-1:0]          tail_sum;
  logic [IDX_W-1:0]       back_idx;
  logic [IDX_W-1:0]       tail_idx;
  logic [IDX_W-1:0]       head_inc;
  logic [IDX_W-1:0]       raddr;
  logic [RAM_W-1:0]       rdata;
  logic [RAM_W-1:0]       wdata;
  logic signed [SAMPLE_BITS-1:0] rd_value;
  logic [POS_W-1:0]       rd_pos;
  logic [AW-1:0]          age;
  logic [CNT_W-1:0]       fill_inc;
  logic [POS_W-1:0]       pos_inc;
  logic                   out_free;

  assign cfg_ext = EW'(cfg_window_r);

  always_comb begin
    if (cfg_ext == '0) begin
      eff_ext = EW'(1);
    end else if (cfg_ext > EW'(WINDOW_MAX)) begin
      eff_ext = EW'(WINDOW_MAX);
    end else begin
      eff_ext = cfg_ext;
    end
  end

  assign eff_w = CNT_W'(eff_ext);

  assign back_sum = SW'(cand_head_r) + SW'(cand_count_r) - SW'(1);
  assign tail_sum = SW'(cand_head_r) + SW'(cand_count_r);
  assign back_idx = (back_sum >= SW'(WINDOW_MAX)) ? IDX_W'(back_sum - SW'(WINDOW_MAX))
                                                  : IDX_W'(back_sum);
  assign tail_idx = (tail_sum >= SW'(WINDOW_MAX)) ? IDX_W'(tail_sum - SW'(WINDOW_MAX))
                                                  : IDX_W'(tail_sum);
  assign head_inc = (cand_head_r == IDX_W'(WINDOW_MAX - 1)) ? '0 : cand_head_r + IDX_W'(1);

  assign raddr = cmd.rd_front ? cand_head_r : back_idx;
  assign wdata = {pos_r, s_r};

  swm_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WINDOW_MAX)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (tail_idx),
    .wdata (wdata),
    .re    (cmd.rd_front | cmd.rd_back),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_value = $signed(rdata[SAMPLE_BITS-1:0]);
  assign rd_pos   = rdata[RAM_W-1:SAMPLE_BITS];

  // position distance modulo the position range
  assign age = (pos_r >= rd_pos) ? AW'(pos_r) - AW'(rd_pos)
                                 : AW'(pos_r) + AW'(POS_MOD) - AW'(rd_pos);

  assign fill_inc = (fill_count_r == CNT_W'(WINDOW_MAX)) ? fill_count_r
                                                        : fill_count_r + CNT_W'(1);
  assign pos_inc  = (pos_r == POS_W'(POS_MOD - 1)) ? '0 : pos_r + POS_W'(1);
  assign out_free = !out_valid_r || out_ready;

  assign status.cnt_zero     = (cand_count_r == '0);
  assign status.front_old    = (age >= AW'(eff_w));
  assign status.back_greater = (rd_value > s_r);
  assign status.result_due   = (fill_inc >= eff_w);
  assign status.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_window_r <= CFG_W'(WINDOW_RESET);
      cand_count_r <= '0;
      cand_head_r  <= '0;
      fill_count_r <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_window_r <= cfg_wdata;
      end
      if (cmd.load && restart) begin
        cand_count_r <= '0;
        cand_head_r  <= '0;
        fill_count_r <= '0;
      end
      if (cmd.front_pop) begin
        cand_head_r  <= head_inc;
        cand_count_r <= cand_count_r - CNT_W'(1);
      end
      if (cmd.back_pop) begin
        cand_count_r <= cand_count_r - CNT_W'(1);
      end
      if (cmd.write) begin
        cand_count_r <= cand_count_r + CNT_W'(1);
        fill_count_r <= fill_inc;
        pos_r        <= pos_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r <= sample;
    end
    if (cmd.front_keep) begin
      front_r <= rd_value;
    end
    if (cmd.write) begin
      pend_r <= (cand_count_r == '0) ? s_r : front_r;
    end
    if (cmd.emit) begin
      out_data_r <= pend_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cand_count_r <= CNT_W'(WINDOW_MAX))
    else $error("candidate count above depth");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(WINDOW_MAX))
    else $error("fill count above depth");

  a_write_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write |=> (cand_count_r != '0))
    else $error("deque empty after append");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cand_head_r <= IDX_W'(WINDOW_MAX - 1))
    else $error("head index out of range");

endmodule

`default_nettype wire

[design/sliding_window_minimum.sv]
// ----------------------------------------------------------------------------
// sliding_window_minimum
// Streaming minimum over the last window_size signed samples.
// ----------------------------------------------------------------------------
// Each accepted sample runs front checks (aging out old candidates), then back
// checks (popping larger candidates), then its append, which an empty deque
// reaches directly; every deque check is one registered read of the candidate
// RAM and a compare. A due result then waits while the output register is held;
// out_tvalid rises at the edge where in_tready returns; no new sample is taken
// before the last one is through. Reset (rst_n low, synchronous) empties the
// deque and window and sets window_size to 3; the candidate RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_minimum
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    in_tdata,  // sample
  input  wire logic                                in_tuser,  // restart
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    out_tdata, // window_min
  input  wire logic                                cfg_we,
  input  wire logic [CFG_W-1:0]                    cfg_wdata  // window_size
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  swm_cmd_t                      cmd;
  swm_status_t                   status;
  logic signed [SAMPLE_BITS-1:0] min_data;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  swm_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .sample    ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .restart   (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (min_data)
  );

  assign out_tdata = DATA_W'($unsigned(min_data));

endmodule

`default_nettype wire
